>>> hw/rtl/scb_pkg.sv
// Shared constants, types and the arctangent table of the steering command block.
`timescale 1ns / 1ps
package scb_pkg;

    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 24;
    localparam int DIST_GAIN_W   = 24;
    localparam int LIMIT_W       = 15;
    localparam int ANGLE_GAIN_W  = 16;
    localparam int SPEED_W       = 15;
    localparam int TURN_W        = 16;
    localparam int Z_W           = 26;
    localparam int ATAN_ENTRIES  = 24;
    localparam int CORDIC_SHIFT  = 30;
    localparam int ROOT_FRAC     = 16;
    localparam int DIST_SHIFT    = 25;
    localparam int ANGLE_SHIFT   = 24;

    localparam logic [CFG_IDX_W-1:0] REG_REF_X       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REF_Y       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIST_GAIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DIST    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LINEAR  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_GAIN  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ANGULAR = 3'd6;

    localparam int RST_REF_X       = 320;
    localparam int RST_REF_Y       = 480;
    localparam int RST_DIST_GAIN   = 13422;
    localparam int RST_MIN_DIST    = 328;
    localparam int RST_MAX_LINEAR  = 9830;
    localparam int RST_ANGLE_GAIN  = 16384;
    localparam int RST_MAX_ANGULAR = 16384;

    typedef struct packed {
        logic                  vld;
        logic                  pos;
        logic signed [Z_W-1:0] z;
    } t_ang;

    function automatic logic signed [Z_W-1:0] atan_q24(input logic [4:0] idx);
        logic signed [Z_W-1:0] v;
        unique case (idx)
            5'd0:  v = Z_W'(13176795);
            5'd1:  v = Z_W'(7778716);
            5'd2:  v = Z_W'(4110060);
            5'd3:  v = Z_W'(2086331);
            5'd4:  v = Z_W'(1047214);
            5'd5:  v = Z_W'(524117);
            5'd6:  v = Z_W'(262123);
            5'd7:  v = Z_W'(131069);
            5'd8:  v = Z_W'(65536);
            5'd9:  v = Z_W'(32768);
            5'd10: v = Z_W'(16384);
            5'd11: v = Z_W'(8192);
            5'd12: v = Z_W'(4096);
            5'd13: v = Z_W'(2048);
            5'd14: v = Z_W'(1024);
            5'd15: v = Z_W'(512);
            5'd16: v = Z_W'(256);
            5'd17: v = Z_W'(128);
            5'd18: v = Z_W'(64);
            5'd19: v = Z_W'(32);
            5'd20: v = Z_W'(16);
            5'd21: v = Z_W'(8);
            5'd22: v = Z_W'(4);
            5'd23: v = Z_W'(2);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> hw/rtl/scb_sqrt.sv
// Pipelined squared-length and digit-by-digit square root, one root bit per stage.
`timescale 1ns / 1ps
module scb_sqrt #(
    parameter int COORD_BITS = 12,
    localparam int DW = COORD_BITS + 2,
    localparam int RW = COORD_BITS + 18
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic signed [DW-1:0] i_dx,
    input  logic signed [DW-1:0] i_dy,
    output logic                 o_valid,
    output logic [RW-1:0]        o_root
);
    import scb_pkg::*;

    localparam int SQW  = 2 * DW - 2;
    localparam int RADW = 2 * RW;
    localparam int REMW = RW + 2;
    localparam int PADW = 2 * ROOT_FRAC;

    logic signed [2*DW-1:0] w_px;
    logic signed [2*DW-1:0] w_py;
    logic [SQW-1:0]         r_sqx;
    logic [SQW-1:0]         r_sqy;
    logic                   r_v_sq;

    logic [REMW-1:0] r_rem  [0:RW];
    logic [RW-1:0]   r_root [0:RW];
    logic [RADW-1:0] r_rad  [0:RW];
    logic            r_vld  [0:RW];

    assign w_px = i_dx * i_dx;
    assign w_py = i_dy * i_dy;

    always_ff @(posedge i_clk) begin
        r_sqx     <= w_px[SQW-1:0];
        r_sqy     <= w_py[SQW-1:0];
        r_rem[0]  <= '0;
        r_root[0] <= '0;
        r_rad[0]  <= {1'b0, {1'b0, r_sqx} + {1'b0, r_sqy}, {PADW{1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_sq   <= 1'b0;
            r_vld[0] <= 1'b0;
        end else begin
            r_v_sq   <= i_valid;
            r_vld[0] <= r_v_sq;
        end
    end

    for (genvar k = 0; k < RW; k++) begin : g_step
        logic [1:0]      pair;
        logic [REMW-1:0] remx;
        logic [REMW-1:0] trial;
        logic [REMW-1:0] diff;
        logic            ge;

        assign pair  = r_rad[k][RADW-1 -: 2];
        assign remx  = {r_rem[k][REMW-3:0], pair};
        assign trial = {r_root[k], 2'b01};
        assign ge    = (remx >= trial);
        assign diff  = remx - trial;

        always_ff @(posedge i_clk) begin
            r_rem[k+1]  <= ge ? diff : remx;
            r_root[k+1] <= {r_root[k][RW-2:0], ge};
            r_rad[k+1]  <= r_rad[k] << 2;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else begin
                r_vld[k+1] <= r_vld[k];
            end
        end
    end

    assign o_valid = r_vld[RW];
    assign o_root  = r_root[RW];

endmodule

>>> hw/rtl/scb_cordic.sv
// Unrolled vectoring CORDIC that gives the arctangent of dx over dy in radians Q.24.
`timescale 1ns / 1ps
module scb_cordic #(
    parameter int DW     = 14,
    parameter int STAGES = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic                 i_pos,
    input  logic signed [DW-1:0] i_dx,
    input  logic signed [DW-1:0] i_dy,
    output scb_pkg::t_ang        o_ang
);
    import scb_pkg::*;

    localparam int XW = DW + 32;
    localparam int NC = (STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : STAGES;

    logic signed [XW-1:0]  r_x   [1:NC];
    logic signed [XW-1:0]  r_y   [1:NC];
    logic signed [Z_W-1:0] r_z   [1:NC];
    logic                  r_pos [1:NC];
    logic                  r_vld [1:NC];

    for (genvar k = 0; k < NC; k++) begin : g_stage
        logic signed [XW-1:0]  x_in;
        logic signed [XW-1:0]  y_in;
        logic signed [Z_W-1:0] z_in;
        logic                  p_in;
        logic                  v_in;
        logic signed [XW-1:0]  xs;
        logic signed [XW-1:0]  ys;
        logic signed [XW-1:0]  n_x;
        logic signed [XW-1:0]  n_y;
        logic signed [Z_W-1:0] n_z;

        if (k == 0) begin : g_first
            assign x_in = XW'(i_dy) <<< CORDIC_SHIFT;
            assign y_in = XW'(i_dx) <<< CORDIC_SHIFT;
            assign z_in = '0;
            assign p_in = i_pos;
            assign v_in = i_valid;
        end else begin : g_next
            assign x_in = r_x[k];
            assign y_in = r_y[k];
            assign z_in = r_z[k];
            assign p_in = r_pos[k];
            assign v_in = r_vld[k];
        end

        assign xs = x_in >>> k;
        assign ys = y_in >>> k;

        always_comb begin
            if (!y_in[XW-1]) begin
                n_x = x_in + ys;
                n_y = y_in - xs;
                n_z = z_in + atan_q24(5'(k));
            end else begin
                n_x = x_in - ys;
                n_y = y_in + xs;
                n_z = z_in - atan_q24(5'(k));
            end
        end

        always_ff @(posedge i_clk) begin
            r_x[k+1]   <= n_x;
            r_y[k+1]   <= n_y;
            r_z[k+1]   <= n_z;
            r_pos[k+1] <= p_in;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else begin
                r_vld[k+1] <= v_in;
            end
        end
    end

    assign o_ang = '{vld: r_vld[NC], pos: r_pos[NC], z: r_z[NC]};

endmodule

>>> hw/rtl/steering_command_from_box.sv
// Top level: turns one tracked bounding box into a forward speed and a turn rate.
`timescale 1ns / 1ps
// The block takes one box per clock whenever busy is low; busy is high only while reset is
// applied and for the cycle after. Each box gives exactly one result, shown on the result
// ports for one cycle with o_strobe high. The path from an accepted box to its result runs
// through the input register, the square-root pipeline, the scaling register and the
// output register. The square-root pipeline resolves one root bit per stage over
// COORD_BITS + 18 stages; the CORDIC runs alongside it and is delayed to match. The
// receiver cannot stall the block, so results leave in the order the boxes arrived.
// Registers may be written only while no box is in flight.
module steering_command_from_box #(
    parameter int COORD_BITS    = 12,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [scb_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [scb_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic signed [COORD_BITS-1:0]         i_box_left,
    input  logic signed [COORD_BITS-1:0]         i_box_top,
    input  logic [COORD_BITS-1:0]                i_box_width,
    input  logic [COORD_BITS-1:0]                i_box_height,
    output logic                                 o_strobe,
    output logic [scb_pkg::SPEED_W-1:0]          o_line_speed,
    output logic signed [scb_pkg::TURN_W-1:0]    o_turn_rate,
    output logic                                 o_moving
);
    import scb_pkg::*;

    localparam int DW    = COORD_BITS + 2;
    localparam int RW    = COORD_BITS + 18;
    localparam int NC    = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;
    localparam int DLY   = 2 + RW - NC;
    localparam int DPW   = DIST_GAIN_W + RW;
    localparam int DISTW = DPW - DIST_SHIFT;
    localparam int PW    = Z_W + ANGLE_GAIN_W + 1;
    localparam int TW    = PW - ANGLE_SHIFT;
    localparam int LAT   = RW + 5;

    logic [COORD_BITS-1:0]   r_ref_x;
    logic [COORD_BITS-1:0]   r_ref_y;
    logic [DIST_GAIN_W-1:0]  r_dist_gain;
    logic [LIMIT_W-1:0]      r_min_dist;
    logic [LIMIT_W-1:0]      r_max_linear;
    logic [ANGLE_GAIN_W-1:0] r_angle_gain;
    logic [LIMIT_W-1:0]      r_max_angular;
    logic                    r_busy;

    logic                    w_accept;
    logic                    w_cfg_we;
    logic signed [DW-1:0]    w_left;
    logic signed [DW-1:0]    w_top;
    logic signed [DW-1:0]    w_half_w;
    logic signed [DW-1:0]    w_half_h;
    logic signed [DW-1:0]    w_refx;
    logic signed [DW-1:0]    w_refy;
    logic signed [DW-1:0]    w_dx;
    logic signed [DW-1:0]    w_dy;

    logic signed [DW-1:0]    r_dx;
    logic signed [DW-1:0]    r_dy;
    logic                    r_pos;
    logic                    r_v0;

    logic                    w_root_vld;
    logic [RW-1:0]           w_root;
    t_ang                    w_ang;
    t_ang                    r_dly [0:DLY-1];

    logic [DPW-1:0]          w_dprod;
    logic signed [PW-1:0]    w_tprod;
    logic [DISTW-1:0]        r_dist;
    logic signed [TW-1:0]    r_tprod;
    logic                    r_pos_m;
    logic                    r_v_m;

    logic signed [TW-1:0]    w_lim;
    logic signed [TW-1:0]    w_turn;
    logic                    n_moving;
    logic [SPEED_W-1:0]      n_speed;
    logic signed [TURN_W-1:0] n_turn;

    logic                    r_strobe;
    logic                    r_moving;
    logic [SPEED_W-1:0]      r_speed;
    logic signed [TURN_W-1:0] r_turn;

    assign busy        = r_busy;
    assign o_cfg_ready = ~r_busy;
    assign w_accept    = start & ~r_busy;
    assign w_cfg_we    = i_cfg_valid & ~r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy        <= 1'b1;
            r_ref_x       <= COORD_BITS'(RST_REF_X);
            r_ref_y       <= COORD_BITS'(RST_REF_Y);
            r_dist_gain   <= DIST_GAIN_W'(RST_DIST_GAIN);
            r_min_dist    <= LIMIT_W'(RST_MIN_DIST);
            r_max_linear  <= LIMIT_W'(RST_MAX_LINEAR);
            r_angle_gain  <= ANGLE_GAIN_W'(RST_ANGLE_GAIN);
            r_max_angular <= LIMIT_W'(RST_MAX_ANGULAR);
        end else begin
            r_busy <= 1'b0;
            if (w_cfg_we) begin
                unique case (i_cfg_index)
                    REG_REF_X:       r_ref_x       <= i_cfg_data[COORD_BITS-1:0];
                    REG_REF_Y:       r_ref_y       <= i_cfg_data[COORD_BITS-1:0];
                    REG_DIST_GAIN:   r_dist_gain   <= i_cfg_data[DIST_GAIN_W-1:0];
                    REG_MIN_DIST:    r_min_dist    <= i_cfg_data[LIMIT_W-1:0];
                    REG_MAX_LINEAR:  r_max_linear  <= i_cfg_data[LIMIT_W-1:0];
                    REG_ANGLE_GAIN:  r_angle_gain  <= i_cfg_data[ANGLE_GAIN_W-1:0];
                    REG_MAX_ANGULAR: r_max_angular <= i_cfg_data[LIMIT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Box center offsets from the reference point, with truncating halving of the size.
    assign w_left   = DW'(i_box_left);
    assign w_top    = DW'(i_box_top);
    assign w_half_w = DW'({1'b0, i_box_width[COORD_BITS-1:1]});
    assign w_half_h = DW'({1'b0, i_box_height[COORD_BITS-1:1]});
    assign w_refx   = DW'({1'b0, r_ref_x});
    assign w_refy   = DW'({1'b0, r_ref_y});
    assign w_dx     = w_refx - w_left - w_half_w;
    assign w_dy     = w_refy - w_top - w_half_h;

    always_ff @(posedge i_clk) begin
        r_dx  <= w_dx;
        r_dy  <= w_dy;
        r_pos <= ~w_dy[DW-1] & (|w_dy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else begin
            r_v0 <= w_accept;
        end
    end

    scb_sqrt #(
        .COORD_BITS(COORD_BITS)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v0),
        .i_dx    (r_dx),
        .i_dy    (r_dy),
        .o_valid (w_root_vld),
        .o_root  (w_root)
    );

    scb_cordic #(
        .DW     (DW),
        .STAGES (NC)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v0),
        .i_pos   (r_pos),
        .i_dx    (r_dx),
        .i_dy    (r_dy),
        .o_ang   (w_ang)
    );

    // The angle finishes before the root, so it waits here until the two line up.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DLY; i++) begin
                r_dly[i] <= '0;
            end
        end else begin
            r_dly[0] <= w_ang;
            for (int i = 1; i < DLY; i++) begin
                r_dly[i] <= r_dly[i-1];
            end
        end
    end

    assign w_dprod = DPW'(r_dist_gain) * DPW'(w_root);
    assign w_tprod = $signed({1'b0, r_angle_gain}) * r_dly[DLY-1].z;

    always_ff @(posedge i_clk) begin
        r_dist  <= w_dprod[DPW-1:DIST_SHIFT];
        r_tprod <= w_tprod[PW-1:ANGLE_SHIFT];
        r_pos_m <= r_dly[DLY-1].pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_m <= 1'b0;
        end else begin
            r_v_m <= w_root_vld;
        end
    end

    assign w_lim = TW'({1'b0, r_max_angular});

    always_comb begin
        n_moving = r_v_m & r_pos_m & (r_dist > DISTW'(r_min_dist));
        if (r_tprod > w_lim) begin
            w_turn = w_lim;
        end else if (r_tprod < -w_lim) begin
            w_turn = -w_lim;
        end else begin
            w_turn = r_tprod;
        end
        if (!n_moving) begin
            n_speed = '0;
            n_turn  = '0;
        end else begin
            n_speed = (r_dist < DISTW'(r_max_linear)) ? r_dist[SPEED_W-1:0] : r_max_linear;
            n_turn  = w_turn[TURN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
            r_moving <= 1'b0;
        end else begin
            r_strobe <= r_v_m;
            r_moving <= n_moving;
        end
    end

    always_ff @(posedge i_clk) begin
        r_speed <= n_speed;
        r_turn  <= n_turn;
    end

    assign o_strobe     = r_strobe;
    assign o_moving     = r_moving;
    assign o_line_speed = r_speed;
    assign o_turn_rate  = r_turn;

    a_paths_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_root_vld == r_dly[DLY-1].vld)
        else $error("Root and angle pipelines are out of step.");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##LAT o_strobe)
        else $error("Accepted box did not produce a result at the expected cycle.");

    a_moving_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_moving |-> o_strobe)
        else $error("Moving flag raised without a result strobe.");

    a_stop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_moving) |-> (o_line_speed == '0 && o_turn_rate == '0))
        else $error("Stop result carries a nonzero command.");

endmodule

>>> bench/tb_steering_command_from_box.sv
// Self-checking testbench for the steering command block with a bit-exact predictor.
`timescale 1ns / 1ps
module tb_steering_command_from_box;
    import scb_pkg::*;

    localparam int COORD_BITS     = 12;
    localparam int CORDIC_STAGES  = 16;
    localparam int LATENCY        = COORD_BITS + 22;
    localparam int RANDOM_BOXES   = 90;
    localparam int NUM_PHASES     = 6;
    localparam int STALL_LIMIT    = 2000;
    localparam int MAX_REPORTS    = 60;
    localparam int DIRECTED_COUNT = 13;

    localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

    localparam longint ARCTAN_Q24 [24] = '{
        13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
        256, 128, 64, 32, 16, 8, 4, 2
    };

    typedef struct packed {
        logic signed [COORD_BITS-1:0] left;
        logic signed [COORD_BITS-1:0] top;
        logic [COORD_BITS-1:0]        width;
        logic [COORD_BITS-1:0]        height;
    } t_box;

    typedef struct packed {
        logic [SPEED_W-1:0]        speed;
        logic signed [TURN_W-1:0]  turn;
        logic                      moving;
    } t_steer_cmd;

    typedef struct packed {
        t_box       box;
        bit         typed;
        t_steer_cmd cmd;
    } t_box_case;

    logic                          i_clk;
    logic                          i_rst_n      = 1'b0;
    logic                          start        = 1'b0;
    logic                          busy;
    logic                          i_cfg_valid  = 1'b0;
    logic                          o_cfg_ready;
    logic [CFG_IDX_W-1:0]          i_cfg_index  = '0;
    logic [CFG_DATA_W-1:0]         i_cfg_data   = '0;
    logic signed [COORD_BITS-1:0]  i_box_left   = '0;
    logic signed [COORD_BITS-1:0]  i_box_top    = '0;
    logic [COORD_BITS-1:0]         i_box_width  = '0;
    logic [COORD_BITS-1:0]         i_box_height = '0;
    logic                          o_strobe;
    logic [SPEED_W-1:0]            o_line_speed;
    logic signed [TURN_W-1:0]      o_turn_rate;
    logic                          o_moving;

    logic [COORD_BITS-1:0]   cfg_ref_x       = COORD_BITS'(RST_REF_X);
    logic [COORD_BITS-1:0]   cfg_ref_y       = COORD_BITS'(RST_REF_Y);
    logic [DIST_GAIN_W-1:0]  cfg_dist_gain   = DIST_GAIN_W'(RST_DIST_GAIN);
    logic [LIMIT_W-1:0]      cfg_min_dist    = LIMIT_W'(RST_MIN_DIST);
    logic [LIMIT_W-1:0]      cfg_max_linear  = LIMIT_W'(RST_MAX_LINEAR);
    logic [ANGLE_GAIN_W-1:0] cfg_angle_gain  = ANGLE_GAIN_W'(RST_ANGLE_GAIN);
    logic [LIMIT_W-1:0]      cfg_max_angular = LIMIT_W'(RST_MAX_ANGULAR);

    t_steer_cmd expected_cmds[$];
    int         mismatch_cnt = 0;
    int         quiet_cycles = 0;
    int         idle_pct     = 0;

    t_box_case directed_boxes [DIRECTED_COUNT] = '{
        '{'{320, 480, 0, 0},          1'b1, '{0, 0, 0}},
        '{'{2047, 2047, 4095, 4095},  1'b1, '{0, 0, 0}},
        '{'{320, 481, 0, 0},          1'b1, '{0, 0, 0}},
        '{'{320, 479, 1, 1},          1'b1, '{0, 0, 0}},
        '{'{-2048, 479, 0, 1},        1'b1, '{9830, 16384, 1}},
        '{'{2047, 479, 4095, 0},      1'b1, '{9830, -16384, 1}},
        '{'{320, -2048, 0, 0},        1'b0, '{0, 0, 0}},
        '{'{-2048, -2048, 4095, 4095}, 1'b0, '{0, 0, 0}},
        '{'{-2048, -2048, 0, 0},      1'b0, '{0, 0, 0}},
        '{'{2047, -2048, 0, 0},       1'b0, '{0, 0, 0}},
        '{'{319, 400, 3, 1},          1'b0, '{0, 0, 0}},
        '{'{100, 300, 40, 60},        1'b0, '{0, 0, 0}},
        '{'{520, 470, 10, 2},         1'b0, '{0, 0, 0}}
    };

    steering_command_from_box #(
        .COORD_BITS    (COORD_BITS),
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_box_left   (i_box_left),
        .i_box_top    (i_box_top),
        .i_box_width  (i_box_width),
        .i_box_height (i_box_height),
        .o_strobe     (o_strobe),
        .o_line_speed (o_line_speed),
        .o_turn_rate  (o_turn_rate),
        .o_moving     (o_moving)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic t_steer_cmd steer_predict(input t_box b);
        longint            cx, cy, dx, dy, x, y, z, xs, ys, turn, lim;
        longint unsigned   sq, rem, root, trial, pair, scaled_len;
        t_steer_cmd        r;
        int                k;
        cx = longint'(b.left) + longint'(b.width) / 2;
        cy = longint'(b.top) + longint'(b.height) / 2;
        dx = longint'(cfg_ref_x) - cx;
        dy = longint'(cfg_ref_y) - cy;
        sq = dx * dx + dy * dy;
        rem = 0;
        root = 0;
        for (k = 0; k < 34; k++) begin
            pair = (k < 18) ? ((sq >> (34 - 2 * k)) & 3) : 0;
            rem = (rem << 2) | pair;
            trial = (root << 2) | 1;
            if (rem >= trial) begin
                rem -= trial;
                root = (root << 1) | 1;
            end else begin
                root = root << 1;
            end
        end
        scaled_len = (longint'(cfg_dist_gain) * root) >> DIST_SHIFT;
        r = '0;
        if (dy > 0 && scaled_len > cfg_min_dist) begin
            r.moving = 1'b1;
            r.speed = (scaled_len < cfg_max_linear) ? scaled_len[SPEED_W-1:0] : cfg_max_linear;
            x = dy <<< CORDIC_SHIFT;
            y = dx <<< CORDIC_SHIFT;
            z = 0;
            for (k = 0; k < CORDIC_STAGES && k < 24; k++) begin
                xs = x >>> k;
                ys = y >>> k;
                if (y >= 0) begin
                    x += ys;
                    y -= xs;
                    z += ARCTAN_Q24[k];
                end else begin
                    x -= ys;
                    y += xs;
                    z -= ARCTAN_Q24[k];
                end
            end
            turn = (longint'(cfg_angle_gain) * z) >>> ANGLE_SHIFT;
            lim = longint'(cfg_max_angular);
            if (turn > lim) turn = lim;
            if (turn < -lim) turn = -lim;
            r.turn = turn[TURN_W-1:0];
        end
        return r;
    endfunction

    // Mostly boxes ahead of the reference point, near and far, so the move path is exercised.
    function automatic t_box gen_box();
        t_box b;
        int   w, h, dx, dy, lft, tp;
        if ($urandom_range(0, 3) == 0) begin
            b.left = COORD_BITS'($urandom);
            b.top = COORD_BITS'($urandom);
            b.width = COORD_BITS'($urandom);
            b.height = COORD_BITS'($urandom);
            return b;
        end
        w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 120);
        h = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 120);
        dx = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 80) - 40
                                         : $urandom_range(0, 4000) - 2000;
        case ($urandom_range(0, 7))
            0:       dy = $urandom_range(0, 6) - 5;
            1, 2, 3: dy = $urandom_range(1, 40);
            default: dy = $urandom_range(1, 2500);
        endcase
        lft = int'(cfg_ref_x) - dx - w / 2;
        tp = int'(cfg_ref_y) - dy - h / 2;
        if (lft < -2048) lft = -2048;
        if (lft > 2047) lft = 2047;
        if (tp < -2048) tp = -2048;
        if (tp > 2047) tp = 2047;
        b.left = lft[COORD_BITS-1:0];
        b.top = tp[COORD_BITS-1:0];
        b.width = w[COORD_BITS-1:0];
        b.height = h[COORD_BITS-1:0];
        return b;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data[CFG_DATA_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_REF_X:       cfg_ref_x = data[COORD_BITS-1:0];
            REG_REF_Y:       cfg_ref_y = data[COORD_BITS-1:0];
            REG_DIST_GAIN:   cfg_dist_gain = data[DIST_GAIN_W-1:0];
            REG_MIN_DIST:    cfg_min_dist = data[LIMIT_W-1:0];
            REG_MAX_LINEAR:  cfg_max_linear = data[LIMIT_W-1:0];
            REG_ANGLE_GAIN:  cfg_angle_gain = data[ANGLE_GAIN_W-1:0];
            REG_MAX_ANGULAR: cfg_max_angular = data[LIMIT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic program_regs(input int unsigned ref_x, ref_y, dist_gain,
                                thresh, max_linear, angle_gain, max_angular);
        write_reg(REG_REF_X, ref_x);
        write_reg(REG_REF_Y, ref_y);
        write_reg(REG_DIST_GAIN, dist_gain);
        write_reg(REG_MIN_DIST, thresh);
        write_reg(REG_MAX_LINEAR, max_linear);
        write_reg(REG_ANGLE_GAIN, angle_gain);
        write_reg(REG_MAX_ANGULAR, max_angular);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_box(input t_box b, input bit typed, input t_steer_cmd cmd);
        if ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < idle_pct);
        end
        start <= 1'b1;
        i_box_left <= b.left;
        i_box_top <= b.top;
        i_box_width <= b.width;
        i_box_height <= b.height;
        do @(posedge i_clk); while (busy);
        expected_cmds = {expected_cmds, (typed ? cmd : steer_predict(b))};
    endtask

    always @(posedge i_clk) begin : cmd_check
        t_steer_cmd want;
        if (i_rst_n && o_strobe) begin
            if (expected_cmds.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= MAX_REPORTS)
                    $display("%0t: unexpected result, expected none, actual %0d %0d %0b",
                             $time, o_line_speed, o_turn_rate, o_moving);
            end else begin
                want = expected_cmds.pop_front();
                if (o_line_speed !== want.speed) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS)
                        $display("%0t: line_speed expected %0d actual %0d",
                                 $time, want.speed, o_line_speed);
                end
                if (o_turn_rate !== want.turn) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS)
                        $display("%0t: turn_rate expected %0d actual %0d",
                                 $time, want.turn, o_turn_rate);
                end
                if (o_moving !== want.moving) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS)
                        $display("%0t: moving expected %0b actual %0b",
                                 $time, want.moving, o_moving);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: idle_pct = 0;
                1: begin
                    idle_pct = 83;
                    write_reg(REG_NONE, $urandom);
                    program_regs($urandom, $urandom, $urandom_range(1000, 60000),
                                 $urandom_range(0, 3000), $urandom, $urandom, $urandom);
                end
                2: begin
                    idle_pct = 31;
                    program_regs('hFFF000, 'h000FFF, 'hFFFFFF, 0, 32767, 65535, 32767);
                end
                3: begin
                    idle_pct = 0;
                    program_regs(4095, 0, 'hFFFFFF, 32767, 0, 0, 0);
                end
                4: begin
                    idle_pct = 83;
                    write_reg(REG_NONE, 'hFFFFFF);
                    program_regs($urandom, $urandom,
                                 $urandom_range(0, 'hFFFFFF) >> $urandom_range(0, 16),
                                 $urandom, $urandom, $urandom, $urandom);
                end
                default: begin
                    idle_pct = 31;
                    program_regs(RST_REF_X, RST_REF_Y, $urandom_range(0, 255),
                                 $urandom_range(0, 40), $urandom, $urandom, $urandom);
                end
            endcase
            if (ph == 0)
                foreach (directed_boxes[n])
                    send_box(directed_boxes[n].box, directed_boxes[n].typed,
                             directed_boxes[n].cmd);
            repeat (RANDOM_BOXES) send_box(gen_box(), 1'b0, '0);
            start <= 1'b0;
            while (expected_cmds.size() != 0) @(posedge i_clk);
        end
        repeat (LATENCY + 6) @(posedge i_clk);
        if (mismatch_cnt == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
